// File: sv/rvl_pkg.sv
// ============================================================================
// rvl_pkg
// Shared widths, types and constants of the look-at reorientation block.
// ============================================================================
package rvl_pkg;

    // Q3.20 data path
    localparam int DW       = 24;
    localparam int FRAC     = 20;
    localparam int TOL_W    = 20;
    localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(105);

    // Normalisation unit
    localparam int NCW      = 26;               // component width at the unit input
    localparam int NSW      = 2 * NCW;          // sum of squares
    localparam int ROOT_W   = NCW;              // one root bit per stage
    localparam int QUO_W    = FRAC + 1;         // quotient bits, result never above 1.0
    localparam int NOW      = FRAC + 2;         // signed unit-vector component
    localparam int DIV_W    = NCW + FRAC + 2;   // dividend width
    localparam int NORM_LAT = 2 + ROOT_W + 1 + QUO_W + 1;

    typedef logic signed [DW-1:0]  t_q20;
    typedef logic signed [NCW-1:0] t_ncomp;
    typedef logic signed [NOW-1:0] t_unit;

    typedef struct packed {
        t_q20 out_x;
        t_q20 out_y;
        t_q20 out_z;
        logic flat_path;
        logic degenerate;
    } t_result;

endpackage

// File: sv/rvl_if.sv
// ============================================================================
// rvl_in_if / rvl_out_if
// Valid/ready channels carrying one input item and one result item.
// ============================================================================
interface rvl_in_if import rvl_pkg::*; ();
    logic valid;
    logic ready;
    t_q20 vec_x;
    t_q20 vec_y;
    t_q20 vec_z;
    t_q20 dir_x;
    t_q20 dir_y;
    t_q20 dir_z;
    t_q20 up_x;
    t_q20 up_y;
    t_q20 up_z;

    modport source (output valid, vec_x, vec_y, vec_z, dir_x, dir_y, dir_z,
                    up_x, up_y, up_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, dir_x, dir_y, dir_z,
                    up_x, up_y, up_z, output ready);
endinterface

interface rvl_out_if import rvl_pkg::*; ();
    logic valid;
    logic ready;
    t_q20 out_x;
    t_q20 out_y;
    t_q20 out_z;
    logic flat_path;
    logic degenerate;

    modport source (output valid, out_x, out_y, out_z, flat_path, degenerate,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, flat_path, degenerate,
                    output ready);
endinterface

// File: sv/rvl_norm.sv
// ============================================================================
// rvl_norm
// Pipelined 3-vector normalisation: squares, sum, bit-per-stage square root,
// bit-per-stage rounded division. Zero length gives zero and flags it.
// ============================================================================
module rvl_norm import rvl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_ncomp i_v [3],
    output logic   o_valid,
    output t_unit  o_u [3],
    output logic   o_degen
);

    localparam t_unit UNIT_ONE = t_unit'(1) << FRAC;

    logic [NORM_LAT-1:0] r_vld;

    // squares
    logic signed [NSW-1:0] w_prod [3];
    logic [NSW-1:0]        r_sq [3];
    t_ncomp                r_v1 [3];

    // root stages, index 0 is the sum register
    logic [NSW-1:0]    r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    t_ncomp            r_sv   [ROOT_W+1][3];

    // division stages, index 0 is the set-up register
    logic [NCW-1:0]    w_abs [3];
    logic [DIV_W-1:0]  r_rr   [QUO_W+1][3];
    logic [QUO_W-1:0]  r_q    [QUO_W+1][3];
    logic [ROOT_W:0]   r_dd   [QUO_W+1];
    logic [2:0]        r_neg  [QUO_W+1];
    logic              r_zero [QUO_W+1];

    t_unit r_ou [3];
    logic  r_odg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NORM_LAT-2:0], i_valid};
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_sq
        assign w_prod[c] = i_v[c] * i_v[c];
        assign w_abs[c]  = r_sv[ROOT_W][c][NCW-1] ? NCW'(-r_sv[ROOT_W][c])
                                                  : NCW'(r_sv[ROOT_W][c]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= unsigned'(w_prod[c]);
                r_v1[c] <= i_v[c];
            end
            r_rem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_root[0] <= '0;
            r_sv[0]   <= r_v1;
        end
    end

    // one root bit per stage, most significant first
    for (genvar g = 0; g < ROOT_W; g++) begin : g_root
        localparam int K = ROOT_W - 1 - g;
        logic [NSW:0] w_trial;
        logic         w_ge;
        assign w_trial = ((NSW+1)'(r_root[g]) << (K + 1)) + ((NSW+1)'(1) << (2 * K));
        assign w_ge    = {1'b0, r_rem[g]} >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= w_ge ? NSW'({1'b0, r_rem[g]} - w_trial) : r_rem[g];
                r_root[g+1] <= w_ge ? (r_root[g] | (ROOT_W'(1) << K)) : r_root[g];
                r_sv[g+1]   <= r_sv[g];
            end
        end
    end

    // set up (2|v|*2^20 + mag) / (2 mag)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_rr[0][c]  <= (DIV_W'(w_abs[c]) << (FRAC + 1)) + DIV_W'(r_root[ROOT_W]);
                r_q[0][c]   <= '0;
                r_neg[0][c] <= r_sv[ROOT_W][c][NCW-1];
            end
            r_dd[0]   <= {r_root[ROOT_W], 1'b0};
            r_zero[0] <= (r_root[ROOT_W] == '0);
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int K = QUO_W - 1 - j;
        logic [DIV_W-1:0] w_sub;
        logic [2:0]       w_ge;
        assign w_sub = DIV_W'(r_dd[j]) << K;
        for (genvar c = 0; c < 3; c++) begin : g_cmp
            assign w_ge[c] = r_rr[j][c] >= w_sub;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_rr[j+1][c] <= w_ge[c] ? r_rr[j][c] - w_sub : r_rr[j][c];
                    r_q[j+1][c]  <= r_q[j][c] | (QUO_W'(w_ge[c]) << K);
                end
                r_dd[j+1]   <= r_dd[j];
                r_neg[j+1]  <= r_neg[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // apply sign, force zero for a zero-length input
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_zero[QUO_W]) begin
                    r_ou[c] <= '0;
                end else if (r_neg[QUO_W][c]) begin
                    r_ou[c] <= -t_unit'(r_q[QUO_W][c]);
                end else begin
                    r_ou[c] <= t_unit'(r_q[QUO_W][c]);
                end
            end
            r_odg <= r_zero[QUO_W];
        end
    end

    assign o_valid = r_vld[NORM_LAT-1];
    assign o_u     = r_ou;
    assign o_degen = r_odg;

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ROOT_W+1] |-> (r_rem[ROOT_W] <= NSW'({r_root[ROOT_W], 1'b0})))
        else $error("root remainder exceeds floor bound");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degen) |-> (o_u[0] == '0 && o_u[1] == '0 && o_u[2] == '0))
        else $error("degenerate normalisation not zero");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_u[0] <= UNIT_ONE && o_u[0] >= -UNIT_ONE &&
                     o_u[1] <= UNIT_ONE && o_u[1] >= -UNIT_ONE &&
                     o_u[2] <= UNIT_ONE && o_u[2] >= -UNIT_ONE))
        else $error("normalised component above one");

endmodule

// File: sv/rvl_ofifo.sv
// ============================================================================
// rvl_ofifo
// Two-entry result queue; its full flag is the pipeline advance condition.
// ============================================================================
module rvl_ofifo import rvl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr,
    input  t_result  i_data,
    output logic     o_full,
    rvl_out_if.source o_out
);

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_rd;

    assign w_rd  = o_out.valid && o_out.ready;
    assign n_cnt = r_cnt + 2'(i_wr) - 2'(w_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full           = (r_cnt == 2'd2);
    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_x      = r_mem[r_rp].out_x;
    assign o_out.out_y      = r_mem[r_rp].out_y;
    assign o_out.out_z      = r_mem[r_rp].out_z;
    assign o_out.flat_path  = r_mem[r_rp].flat_path;
    assign o_out.degenerate = r_mem[r_rp].degenerate;

endmodule

// File: sv/reorient_vector_lookat_frame_top.sv
// ============================================================================
// reorient_vector_lookat_frame_top
// Look-at basis reorientation of a Q3.20 vector, fully pipelined.
// ============================================================================
// Takes one transfer per clock while the result queue has room, and returns
// one result per transfer, in order. Throughput is one item per cycle while
// the queue is not full. The pipeline depth is set mainly by the two
// normalisation units in series, each a chain of 26 square-root stages and
// 21 division stages. A two-entry result queue sits at the output: the whole
// pipeline holds while it is full, so a stalled consumer costs nothing but
// time. There is no clearing pass after reset. The tolerance register resets
// to 105 (about 1e-4 in Q.20) and must only be written while the block is
// empty. When |dot(up,dir) - 1| is below the tolerance, the result is the
// vector with y dropped, normalised; otherwise it is vec.x*x+vec.y*y+vec.z*z
// over the basis z = norm(dir), x = norm(up x z), y = z x x, rounded and saturated.
// ============================================================================
module reorient_vector_lookat_frame_top import rvl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rvl_in_if.sink           i_in,
    rvl_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_data
);

    localparam int DOTW  = 2 * DW + 2;
    localparam int PW    = DW + NOW;       // vector times unit component
    localparam int UPW   = 2 * NOW;        // unit times unit component
    localparam int RND_W = DOTW;
    localparam int RND_O = RND_W - FRAC;
    localparam t_q20 OUT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_q20 OUT_MIN = {1'b1, {(DW-1){1'b0}}};

    // Q.40 to Q.20, half away from zero
    function automatic logic signed [RND_O-1:0] f_rnd(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] m;
        logic [RND_W-1:0] q;
        m = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        q = (m + (RND_W'(1) << (FRAC - 1))) >> FRAC;
        f_rnd = v[RND_W-1] ? -RND_O'(q) : RND_O'(q);
    endfunction

    function automatic t_q20 f_sat(input logic signed [RND_O-1:0] v);
        if (v > RND_O'(OUT_MAX)) begin
            f_sat = OUT_MAX;
        end else if (v < RND_O'(OUT_MIN)) begin
            f_sat = OUT_MIN;
        end else begin
            f_sat = DW'(v);
        end
    endfunction

    logic             w_en;
    logic             w_full;
    logic [TOL_W-1:0] r_tol;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RST;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // Advance every stage together whenever the result queue has room
    assign w_en       = !w_full;
    assign i_in.ready = w_en;

    // ---------------- valid bits ----------------
    logic r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic r_c1_v, r_c2_v, r_y1_v, r_y2_v, r_f1_v, r_f2_v, r_f3_v;
    logic w_n1_v, w_n2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_y1_v <= 1'b0;
            r_y2_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= i_in.valid;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_c1_v <= w_n1_v;
            r_c2_v <= r_c1_v;
            r_y1_v <= w_n2_v;
            r_y2_v <= r_y1_v;
            r_f1_v <= r_y2_v;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    // ---------------- front end: dot(up,dir) and path choice ----------------
    t_q20 r_p1_vec [3], r_p1_dir [3], r_p1_up [3];
    logic signed [2*DW-1:0] r_p2_pd [3];
    t_q20 r_p2_vec [3], r_p2_dir [3], r_p2_up [3];
    logic signed [DOTW-1:0] r_p3_dot;
    t_q20 r_p3_vec [3], r_p3_dir [3], r_p3_up [3];
    t_q20 r_p4_vec [3], r_p4_dir [3], r_p4_up [3];
    logic r_p4_flat;

    logic signed [DOTW:0] w_diff;
    logic [DOTW:0]        w_adiff;
    logic                 w_flat;

    assign w_diff  = (DOTW+1)'(r_p3_dot) - ((DOTW+1)'(1) << (2 * FRAC));
    assign w_adiff = w_diff[DOTW] ? (DOTW+1)'(-w_diff) : (DOTW+1)'(w_diff);
    assign w_flat  = w_adiff < ((DOTW+1)'(r_tol) << FRAC);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_vec <= '{i_in.vec_x, i_in.vec_y, i_in.vec_z};
            r_p1_dir <= '{i_in.dir_x, i_in.dir_y, i_in.dir_z};
            r_p1_up  <= '{i_in.up_x, i_in.up_y, i_in.up_z};
            for (int c = 0; c < 3; c++) begin
                r_p2_pd[c] <= r_p1_up[c] * r_p1_dir[c];
            end
            r_p2_vec <= r_p1_vec;
            r_p2_dir <= r_p1_dir;
            r_p2_up  <= r_p1_up;
            r_p3_dot <= DOTW'(r_p2_pd[0]) + DOTW'(r_p2_pd[1]) + DOTW'(r_p2_pd[2]);
            r_p3_vec <= r_p2_vec;
            r_p3_dir <= r_p2_dir;
            r_p3_up  <= r_p2_up;
            r_p4_flat <= w_flat;
            r_p4_vec  <= r_p3_vec;
            r_p4_dir  <= r_p3_dir;
            r_p4_up   <= r_p3_up;
        end
    end

    // ---------------- first normalisation: dir, or vec with y dropped ----------------
    t_ncomp w_n1_in [3];
    t_unit  w_zb [3];
    logic   w_dg1;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_n1_in[c] = t_ncomp'(r_p4_dir[c]);
            if (r_p4_flat) begin
                w_n1_in[c] = (c == 1) ? t_ncomp'(0) : t_ncomp'(r_p4_vec[c]);
            end
        end
    end

    rvl_norm u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p4_v),
        .i_v     (w_n1_in),
        .o_valid (w_n1_v),
        .o_u     (w_zb),
        .o_degen (w_dg1)
    );

    // carry vec, up and the path alongside the unit
    t_q20 r_d1_vec  [NORM_LAT][3];
    t_q20 r_d1_up   [NORM_LAT][3];
    logic r_d1_flat [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_vec[0]  <= r_p4_vec;
            r_d1_up[0]   <= r_p4_up;
            r_d1_flat[0] <= r_p4_flat;
            for (int s = 1; s < NORM_LAT; s++) begin
                r_d1_vec[s]  <= r_d1_vec[s-1];
                r_d1_up[s]   <= r_d1_up[s-1];
                r_d1_flat[s] <= r_d1_flat[s-1];
            end
        end
    end

    // ---------------- cross(up, z) ----------------
    logic signed [PW-1:0] r_c1_pr [6];
    t_q20   r_c1_vec [3];
    t_unit  r_c1_zb [3];
    logic   r_c1_flat, r_c1_dg;
    t_ncomp r_c2_c [3];
    t_q20   r_c2_vec [3];
    t_unit  r_c2_zb [3];
    logic   r_c2_flat, r_c2_dg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_pr[0] <= r_d1_up[NORM_LAT-1][1] * w_zb[2];
            r_c1_pr[1] <= r_d1_up[NORM_LAT-1][2] * w_zb[1];
            r_c1_pr[2] <= r_d1_up[NORM_LAT-1][2] * w_zb[0];
            r_c1_pr[3] <= r_d1_up[NORM_LAT-1][0] * w_zb[2];
            r_c1_pr[4] <= r_d1_up[NORM_LAT-1][0] * w_zb[1];
            r_c1_pr[5] <= r_d1_up[NORM_LAT-1][1] * w_zb[0];
            r_c1_vec   <= r_d1_vec[NORM_LAT-1];
            r_c1_zb    <= w_zb;
            r_c1_flat  <= r_d1_flat[NORM_LAT-1];
            r_c1_dg    <= w_dg1;
            for (int c = 0; c < 3; c++) begin
                r_c2_c[c] <= NCW'(f_rnd(RND_W'(r_c1_pr[2*c]) - RND_W'(r_c1_pr[2*c+1])));
            end
            r_c2_vec  <= r_c1_vec;
            r_c2_zb   <= r_c1_zb;
            r_c2_flat <= r_c1_flat;
            r_c2_dg   <= r_c1_dg;
        end
    end

    // ---------------- second normalisation: x axis ----------------
    t_unit w_xb [3];
    logic  w_dg2;

    rvl_norm u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c2_v),
        .i_v     (r_c2_c),
        .o_valid (w_n2_v),
        .o_u     (w_xb),
        .o_degen (w_dg2)
    );

    t_q20  r_d2_vec  [NORM_LAT][3];
    t_unit r_d2_zb   [NORM_LAT][3];
    logic  r_d2_flat [NORM_LAT];
    logic  r_d2_dg   [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_vec[0]  <= r_c2_vec;
            r_d2_zb[0]   <= r_c2_zb;
            r_d2_flat[0] <= r_c2_flat;
            r_d2_dg[0]   <= r_c2_dg;
            for (int s = 1; s < NORM_LAT; s++) begin
                r_d2_vec[s]  <= r_d2_vec[s-1];
                r_d2_zb[s]   <= r_d2_zb[s-1];
                r_d2_flat[s] <= r_d2_flat[s-1];
                r_d2_dg[s]   <= r_d2_dg[s-1];
            end
        end
    end

    // ---------------- y = cross(z, x) ----------------
    logic signed [UPW-1:0] r_y1_pr [6];
    t_q20  r_y1_vec [3];
    t_unit r_y1_zb [3], r_y1_xb [3];
    logic  r_y1_flat, r_y1_dg;
    t_unit r_y2_yb [3];
    t_q20  r_y2_vec [3];
    t_unit r_y2_zb [3], r_y2_xb [3];
    logic  r_y2_flat, r_y2_dg;
    t_unit w_zb2 [3];

    assign w_zb2 = r_d2_zb[NORM_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y1_pr[0] <= w_zb2[1] * w_xb[2];
            r_y1_pr[1] <= w_zb2[2] * w_xb[1];
            r_y1_pr[2] <= w_zb2[2] * w_xb[0];
            r_y1_pr[3] <= w_zb2[0] * w_xb[2];
            r_y1_pr[4] <= w_zb2[0] * w_xb[1];
            r_y1_pr[5] <= w_zb2[1] * w_xb[0];
            r_y1_vec   <= r_d2_vec[NORM_LAT-1];
            r_y1_zb    <= w_zb2;
            r_y1_xb    <= w_xb;
            r_y1_flat  <= r_d2_flat[NORM_LAT-1];
            // the flattened path only normalises once
            r_y1_dg    <= r_d2_dg[NORM_LAT-1] || (!r_d2_flat[NORM_LAT-1] && w_dg2);
            for (int c = 0; c < 3; c++) begin
                r_y2_yb[c] <= NOW'(f_rnd(RND_W'(r_y1_pr[2*c]) - RND_W'(r_y1_pr[2*c+1])));
            end
            r_y2_vec  <= r_y1_vec;
            r_y2_zb   <= r_y1_zb;
            r_y2_xb   <= r_y1_xb;
            r_y2_flat <= r_y1_flat;
            r_y2_dg   <= r_y1_dg;
        end
    end

    // ---------------- vec.x*x + vec.y*y + vec.z*z, round, saturate ----------------
    logic signed [PW-1:0]    r_f1_pr [3][3];
    t_unit                   r_f1_zb [3];
    logic                    r_f1_flat, r_f1_dg;
    logic signed [RND_O-1:0] r_f2_s [3];
    t_unit                   r_f2_zb [3];
    logic                    r_f2_flat, r_f2_dg;
    t_result                 r_f3_res;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_f1_pr[c][0] <= r_y2_vec[0] * r_y2_xb[c];
                r_f1_pr[c][1] <= r_y2_vec[1] * r_y2_yb[c];
                r_f1_pr[c][2] <= r_y2_vec[2] * r_y2_zb[c];
                r_f2_s[c] <= f_rnd(RND_W'(r_f1_pr[c][0]) + RND_W'(r_f1_pr[c][1]) +
                                   RND_W'(r_f1_pr[c][2]));
            end
            r_f1_zb   <= r_y2_zb;
            r_f1_flat <= r_y2_flat;
            r_f1_dg   <= r_y2_dg;
            r_f2_zb   <= r_f1_zb;
            r_f2_flat <= r_f1_flat;
            r_f2_dg   <= r_f1_dg;
            if (r_f2_flat) begin
                r_f3_res.out_x <= t_q20'(r_f2_zb[0]);
                r_f3_res.out_y <= t_q20'(r_f2_zb[1]);
                r_f3_res.out_z <= t_q20'(r_f2_zb[2]);
            end else begin
                r_f3_res.out_x <= f_sat(r_f2_s[0]);
                r_f3_res.out_y <= f_sat(r_f2_s[1]);
                r_f3_res.out_z <= f_sat(r_f2_s[2]);
            end
            r_f3_res.flat_path  <= r_f2_flat;
            r_f3_res.degenerate <= r_f2_dg;
        end
    end

    // ---------------- result queue ----------------
    rvl_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_f3_v && w_en),
        .i_data  (r_f3_res),
        .o_full  (w_full),
        .o_out   (o_out)
    );

    a_flat_no_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.flat_path) |-> (o_out.out_y == '0))
        else $error("flattened result carries a y component");

    a_flat_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.flat_path && o_out.degenerate) |->
            (o_out.out_x == '0 && o_out.out_z == '0))
        else $error("degenerate flattened result not zero");

    a_hold_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f3_v && !w_en) |=> (r_f3_v && $stable(r_f3_res)))
        else $error("waiting result dropped or changed during a stall");

endmodule
